@@ hdl/nsvl_pkg.sv @@
// Shared types and constants of the nearest-sample velocity lookup.
// Holds request, response, queue command and RAM entry formats and the FSM state type.
// Depends on nothing; every other file of the block but nsvl_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package nsvl_pkg;

   // Table geometry
   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   // Field widths
   localparam int POS_W  = 20;
   localparam int VEL_W  = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W   = 2 * DIFF_W - 1;
   // The sum of three squares is below 3 * 2^40, so one extra bit suffices
   localparam int DIST_W = SQ_W + 1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request action codes
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;
   localparam logic [1:0] ACT_NOP   = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_BASE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_CUTOFF = 1'd1;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] out_vel_x;
      logic signed [VEL_W-1:0] out_vel_y;
      logic signed [VEL_W-1:0] out_vel_z;
      logic                    below_cutoff;
      logic                    table_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_LOAD,
      CMD_QUERY
   } cmd_op_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
   } vel_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      vel_type                 vel;
   } sample_type;

   typedef struct packed {
      cmd_op_type op;
      logic       below;
      sample_type smp;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

@@ hdl/nsvl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nsvl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/nsvl_front.sv @@
// Front end: accepts requests, holds the height registers, classifies each request
// and queues it as a command for the back end, dropping no-op requests. Depends on nsvl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsvl_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire nsvl_pkg::req_type                 req_data,
   input  wire logic                              csr_we,
   input  wire logic [nsvl_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [nsvl_pkg::POS_W-1:0]        csr_wdata,
   output logic                                   cmd_valid,
   output nsvl_pkg::cmd_type                      cmd_data,
   input  wire logic                              cmd_pop
);

   logic [nsvl_pkg::POS_W-1:0]  z_base_ff, z_base_in;
   logic [nsvl_pkg::POS_W-1:0]  z_cutoff_ff, z_cutoff_in;
   nsvl_pkg::cmd_type           queue_ff [nsvl_pkg::QUEUE_DEPTH];
   logic [nsvl_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nsvl_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nsvl_pkg::QCNT_W-1:0] fill_ff, fill_in;

   logic                        accept;
   logic                        push;
   nsvl_pkg::cmd_op_type        op;
   logic signed [nsvl_pkg::DIFF_W-1:0] height;
   logic signed [nsvl_pkg::DIFF_W-1:0] cutoff_ext;
   nsvl_pkg::cmd_type           new_cmd;

   // Take configuration writes
   always_comb begin
      z_base_in   = z_base_ff;
      z_cutoff_in = z_cutoff_ff;
      if (csr_we) begin
         unique case (csr_addr)
            nsvl_pkg::CSR_Z_BASE:   z_base_in   = csr_wdata;
            nsvl_pkg::CSR_Z_CUTOFF: z_cutoff_in = csr_wdata;
         endcase
      end
   end

   // Decode the action; no-op requests are accepted and dropped
   always_comb begin
      op   = nsvl_pkg::CMD_CLEAR;
      push = 1'b0;
      unique case (req_data.action)
         nsvl_pkg::ACT_CLEAR: begin
            op   = nsvl_pkg::CMD_CLEAR;
            push = 1'b1;
         end
         nsvl_pkg::ACT_LOAD: begin
            op   = nsvl_pkg::CMD_LOAD;
            push = 1'b1;
         end
         nsvl_pkg::ACT_QUERY: begin
            op   = nsvl_pkg::CMD_QUERY;
            push = 1'b1;
         end
         nsvl_pkg::ACT_NOP: begin
            push = 1'b0;
         end
      endcase
   end

   // Classify the query height against the cutoff
   assign height = $signed({req_data.pos_z[nsvl_pkg::POS_W-1], req_data.pos_z})
                 - $signed({z_base_ff[nsvl_pkg::POS_W-1], z_base_ff});
   assign cutoff_ext = $signed({z_cutoff_ff[nsvl_pkg::POS_W-1], z_cutoff_ff});

   always_comb begin
      new_cmd           = '0;
      new_cmd.op        = op;
      new_cmd.below     = (height < cutoff_ext);
      new_cmd.smp.pos_x = req_data.pos_x;
      new_cmd.smp.pos_y = req_data.pos_y;
      new_cmd.smp.pos_z = req_data.pos_z;
      new_cmd.smp.vel   = '{vel_x: req_data.vel_x, vel_y: req_data.vel_y,
                            vel_z: req_data.vel_z};
   end

   assign req_ready = (fill_ff != nsvl_pkg::QCNT_W'(nsvl_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   assign cmd_valid = (fill_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept && push) begin
         wr_ptr_in = (wr_ptr_ff == nsvl_pkg::QPTR_W'(nsvl_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == nsvl_pkg::QPTR_W'(nsvl_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((accept && push) && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!(accept && push) && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_base_ff   <= '0;
         z_cutoff_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         z_base_ff   <= z_base_in;
         z_cutoff_ff <= z_cutoff_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
      end
   end

   // Store queue entries
   always_ff @(posedge clock) begin
      if (accept && push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hdl/nsvl_back.sv @@
// Back end: executes queued commands against the sample table, scans it for a
// query through a distance pipeline and holds the response register.
// Depends on nsvl_pkg and nsvl_ram.
`timescale 1ns / 1ps
`default_nettype none

module nsvl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire nsvl_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output nsvl_pkg::rsp_type      rsp_data
);

   localparam int SMP_W = $bits(nsvl_pkg::sample_type);

   nsvl_pkg::back_state_type    state_ff, state_in;
   logic [nsvl_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [nsvl_pkg::CNT_W-1:0]  addr_ff, addr_in;
   logic [3:0]                  pv_ff, pv_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   nsvl_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // Query operands and running best
   logic signed [nsvl_pkg::POS_W-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic                        below_ff, below_in;
   logic                        empty_ff, empty_in;
   logic                        have_ff, have_in;
   logic [nsvl_pkg::DIST_W-1:0] best_ff, best_in;
   nsvl_pkg::vel_type           best_vel_ff, best_vel_in;

   // Distance pipeline
   logic signed [nsvl_pkg::DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [nsvl_pkg::SQ_W-1:0]   sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [nsvl_pkg::DIST_W-1:0] dist_ff, dist_in;
   nsvl_pkg::vel_type           vel1_ff, vel1_in, vel2_ff, vel2_in, vel3_ff, vel3_in;

   logic signed [2*nsvl_pkg::DIFF_W-1:0] prod_x, prod_y, prod_z;

   logic                        issue;
   logic                        ram_we;
   logic                        result_fire;
   logic                        cmd_is_query;
   logic [SMP_W-1:0]            rd_word;
   nsvl_pkg::sample_type        rd_smp;

   nsvl_ram #(
      .WIDTH(SMP_W),
      .DEPTH(nsvl_pkg::MAX_SAMPLES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[nsvl_pkg::ADDR_W-1:0]),
      .wr_data(cmd_data.smp),
      .rd_en  (issue),
      .rd_addr(addr_ff[nsvl_pkg::ADDR_W-1:0]),
      .rd_data(rd_word)
   );

   assign rd_smp       = nsvl_pkg::sample_type'(rd_word);
   assign cmd_is_query = (cmd_data.op == nsvl_pkg::CMD_QUERY);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nsvl_pkg::ST_IDLE: begin
            if (cmd_valid && cmd_is_query) begin
               if (cmd_data.below || (count_ff == '0)) begin
                  state_in = nsvl_pkg::ST_DONE;
               end else begin
                  state_in = nsvl_pkg::ST_SCAN;
               end
            end
         end
         nsvl_pkg::ST_SCAN: begin
            if (addr_ff + 1'b1 == count_ff) begin
               state_in = nsvl_pkg::ST_DRAIN;
            end
         end
         nsvl_pkg::ST_DRAIN: begin
            if (pv_ff == '0) begin
               state_in = nsvl_pkg::ST_DONE;
            end
         end
         nsvl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = nsvl_pkg::ST_IDLE;
            end
         end
         default: state_in = nsvl_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_pop     = 1'b0;
      issue       = 1'b0;
      result_fire = 1'b0;
      unique case (state_ff)
         nsvl_pkg::ST_IDLE:  cmd_pop     = cmd_valid;
         nsvl_pkg::ST_SCAN:  issue       = 1'b1;
         nsvl_pkg::ST_DRAIN: issue       = 1'b0;
         nsvl_pkg::ST_DONE:  result_fire = !rsp_valid_ff || rsp_ready;
         default:            issue       = 1'b0;
      endcase
   end

   // Drop loads into a full table
   assign ram_we = cmd_pop && (cmd_data.op == nsvl_pkg::CMD_LOAD)
                && (count_ff < nsvl_pkg::CNT_W'(nsvl_pkg::MAX_SAMPLES));

   // Square the differences
   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;
   assign prod_z = dz_ff * dz_ff;

   // Datapath next values
   always_comb begin
      count_in    = count_ff;
      addr_in     = addr_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      qz_in       = qz_ff;
      below_in    = below_ff;
      empty_in    = empty_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      best_vel_in = best_vel_ff;

      if (cmd_pop && (cmd_data.op == nsvl_pkg::CMD_CLEAR)) begin
         count_in = '0;
      end
      if (ram_we) begin
         count_in = count_ff + 1'b1;
      end

      // Latch query operands and restart the search
      if (cmd_pop && cmd_is_query) begin
         qx_in       = cmd_data.smp.pos_x;
         qy_in       = cmd_data.smp.pos_y;
         qz_in       = cmd_data.smp.pos_z;
         below_in    = cmd_data.below;
         empty_in    = (count_ff == '0);
         have_in     = 1'b0;
         best_vel_in = '0;
         addr_in     = '0;
      end else if (issue) begin
         addr_in = addr_ff + 1'b1;
      end

      // Pipeline stages
      pv_in   = {pv_ff[2:0], issue};
      dx_in   = $signed({qx_ff[nsvl_pkg::POS_W-1], qx_ff})
              - $signed({rd_smp.pos_x[nsvl_pkg::POS_W-1], rd_smp.pos_x});
      dy_in   = $signed({qy_ff[nsvl_pkg::POS_W-1], qy_ff})
              - $signed({rd_smp.pos_y[nsvl_pkg::POS_W-1], rd_smp.pos_y});
      dz_in   = $signed({qz_ff[nsvl_pkg::POS_W-1], qz_ff})
              - $signed({rd_smp.pos_z[nsvl_pkg::POS_W-1], rd_smp.pos_z});
      vel1_in = rd_smp.vel;
      sx_in   = prod_x[nsvl_pkg::SQ_W-1:0];
      sy_in   = prod_y[nsvl_pkg::SQ_W-1:0];
      sz_in   = prod_z[nsvl_pkg::SQ_W-1:0];
      vel2_in = vel1_ff;
      dist_in = {1'b0, sx_ff} + {1'b0, sy_ff} + {1'b0, sz_ff};
      vel3_in = vel2_ff;

      // Keep the earliest strictly nearer sample
      if (pv_ff[3] && (!have_ff || (dist_ff < best_ff))) begin
         have_in     = 1'b1;
         best_in     = dist_ff;
         best_vel_in = vel3_ff;
      end

      // Response register
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.out_vel_x     = best_vel_ff.vel_x;
         rsp_data_in.out_vel_y     = best_vel_ff.vel_y;
         rsp_data_in.out_vel_z     = best_vel_ff.vel_z;
         rsp_data_in.below_cutoff  = below_ff;
         rsp_data_in.table_empty   = empty_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsvl_pkg::ST_IDLE;
         count_ff     <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      below_ff    <= below_in;
      empty_ff    <= empty_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      best_vel_ff <= best_vel_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      dist_ff     <= dist_in;
      vel1_ff     <= vel1_in;
      vel2_ff     <= vel2_in;
      vel3_ff     <= vel3_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nsvl_pkg::CNT_W'(nsvl_pkg::MAX_SAMPLES))
      else $error("sample count beyond table capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nsvl_pkg::ST_SCAN) |-> (addr_ff < count_ff))
      else $error("scan address beyond stored samples");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nsvl_pkg::ST_IDLE) |-> (pv_ff == '0))
      else $error("distance pipeline busy outside a scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == nsvl_pkg::ST_DONE))
      else $error("response raised outside the result state");
`endif

endmodule

`default_nettype wire

@@ hdl/nearest_sample_velocity_lookup_unit.sv @@
// Nearest-sample velocity lookup: request queue front end and table-scan back end.
// Usage:
//   req_*  valid/ready request channel. action clear empties the table, load appends
//          a sample (ignored once the table holds 1024), query asks for the velocity
//          of the nearest stored sample; action three is accepted and dropped.
//   rsp_*  valid/ready response channel, one response per query, in request order.
//   csr_*  write-only registers: index 0 z_base, index 1 z_cutoff. Write them only
//          while the block is idle.
// Timing:
//   A two-entry command queue parts the front from the back, so requests keep being
//   accepted while the back is busy until the queue is full. A clear or load is done
//   as it is dequeued and leaves the back end idle. A query below the cutoff or on an
//   empty table goes straight to the result state; otherwise it scans all N stored
//   samples through one RAM read port, one sample a cycle, and drains the distance
//   pipeline first. Either way the result then waits for a free response register.
// Reset clears the sample count, height registers, queue and response valid flag;
// the table RAM needs no clearing. A stalled receiver holds the response register,
// and the back end then stops at the next completed query until it is taken.
// Depends on nsvl_pkg, nsvl_front, nsvl_back and nsvl_ram.
`timescale 1ns / 1ps
`default_nettype none

module nearest_sample_velocity_lookup_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire nsvl_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output nsvl_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [nsvl_pkg::CSR_IDX_W-1:0] csr_addr,
   input  wire logic [nsvl_pkg::POS_W-1:0]     csr_wdata
);

   logic              cmd_valid;
   logic              cmd_pop;
   nsvl_pkg::cmd_type cmd_data;

   nsvl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop)
   );

   nsvl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for nearest_sample_velocity_lookup_unit.
// Drives random and directed requests, predicts every query response and checks it in order.
// Depends on nsvl_pkg and the RTL of the lookup unit.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 32;

   // Prediction of the sample table and the height registers, plus the responses owed
   class lookup_scoreboard;
      int                stored_x [nsvl_pkg::MAX_SAMPLES];
      int                stored_y [nsvl_pkg::MAX_SAMPLES];
      int                stored_z [nsvl_pkg::MAX_SAMPLES];
      nsvl_pkg::vel_type stored_vel [nsvl_pkg::MAX_SAMPLES];
      int                z_base;
      int                z_cutoff;
      int                sample_count;
      nsvl_pkg::rsp_type pending[$];
      int                mismatches;

      function void write_height(logic [nsvl_pkg::CSR_IDX_W-1:0] idx,
                                 logic [nsvl_pkg::POS_W-1:0] value);
         if (idx == nsvl_pkg::CSR_Z_BASE) begin
            z_base = int'($signed(value));
         end else if (idx == nsvl_pkg::CSR_Z_CUTOFF) begin
            z_cutoff = int'($signed(value));
         end
      endfunction

      // Update the table, or work out the nearest sample for a query
      function void note_request(nsvl_pkg::req_type item);
         int                qx;
         int                qy;
         int                qz;
         longint            dx;
         longint            dy;
         longint            dz;
         longint            dist_sq;
         longint            best;
         bit                found;
         nsvl_pkg::rsp_type nearest;
         qx = int'(item.pos_x);
         qy = int'(item.pos_y);
         qz = int'(item.pos_z);
         case (item.action)
            nsvl_pkg::ACT_CLEAR: begin
               sample_count = 0;
            end
            nsvl_pkg::ACT_LOAD: begin
               // drop loads into a full table
               if (sample_count < nsvl_pkg::MAX_SAMPLES) begin
                  stored_x[sample_count]         = qx;
                  stored_y[sample_count]         = qy;
                  stored_z[sample_count]         = qz;
                  stored_vel[sample_count].vel_x = item.vel_x;
                  stored_vel[sample_count].vel_y = item.vel_y;
                  stored_vel[sample_count].vel_z = item.vel_z;
                  sample_count++;
               end
            end
            nsvl_pkg::ACT_QUERY: begin
               nearest              = '0;
               nearest.table_empty  = (sample_count == 0);
               nearest.below_cutoff = (longint'(qz) - longint'(z_base)) < longint'(z_cutoff);
               found                = 1'b0;
               best                 = 0;
               if (!nearest.below_cutoff) begin
                  // strict compare keeps the earliest sample on a tie
                  for (int i = 0; i < sample_count; i++) begin
                     dx      = longint'(qx) - longint'(stored_x[i]);
                     dy      = longint'(qy) - longint'(stored_y[i]);
                     dz      = longint'(qz) - longint'(stored_z[i]);
                     dist_sq = dx * dx + dy * dy + dz * dz;
                     if (!found || dist_sq < best) begin
                        found             = 1'b1;
                        best              = dist_sq;
                        nearest.out_vel_x = stored_vel[i].vel_x;
                        nearest.out_vel_y = stored_vel[i].vel_y;
                        nearest.out_vel_z = stored_vel[i].vel_z;
                     end
                  end
               end
               pending.push_back(nearest);
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string field, logic [nsvl_pkg::VEL_W-1:0] want,
                                  logic [nsvl_pkg::VEL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(nsvl_pkg::rsp_type got);
         nsvl_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with no query outstanding, expected none got %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("out_vel_x", want.out_vel_x, got.out_vel_x);
         compare_field("out_vel_y", want.out_vel_y, got.out_vel_y);
         compare_field("out_vel_z", want.out_vel_z, got.out_vel_z);
         compare_field("below_cutoff", nsvl_pkg::VEL_W'(want.below_cutoff),
                       nsvl_pkg::VEL_W'(got.below_cutoff));
         compare_field("table_empty", nsvl_pkg::VEL_W'(want.table_empty),
                       nsvl_pkg::VEL_W'(got.table_empty));
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   nsvl_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   nsvl_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [nsvl_pkg::CSR_IDX_W-1:0] csr_addr;
   logic [nsvl_pkg::POS_W-1:0]     csr_wdata;

   lookup_scoreboard sb = new;
   bit               idle_on = 1'b1;
   int               stall_left = 0;
   int               cycle_count = 0;

   nearest_sample_velocity_lookup_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the response side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_data);
      end
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nearest_sample_velocity_lookup_unit verification failed");
         $finish;
      end
   end

   function automatic nsvl_pkg::req_type make_request(logic [1:0] act, int x, int y, int z,
                                                      int vx, int vy, int vz);
      nsvl_pkg::req_type item;
      item.action = act;
      item.pos_x  = nsvl_pkg::POS_W'(x);
      item.pos_y  = nsvl_pkg::POS_W'(y);
      item.pos_z  = nsvl_pkg::POS_W'(z);
      item.vel_x  = nsvl_pkg::VEL_W'(vx);
      item.vel_y  = nsvl_pkg::VEL_W'(vy);
      item.vel_z  = nsvl_pkg::VEL_W'(vz);
      return item;
   endfunction

   // Either the full range or a tight cluster round the origin
   function automatic int pick_coord();
      if ($urandom_range(0, 1) == 0) begin
         return $urandom;
      end
      return $urandom_range(0, 511) - 256;
   endfunction

   // Present one request, with an optional gap first, and hold it until taken
   task automatic send_request(input nsvl_pkg::req_type item);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
   endtask

   // Drop valid, wait for every owed response, then let the back end settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [nsvl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nsvl_pkg::POS_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_height(idx, value);
   endtask

   task automatic set_heights(input int base, input int cutoff);
      wait_idle();
      write_csr(nsvl_pkg::CSR_Z_BASE, nsvl_pkg::POS_W'(base));
      write_csr(nsvl_pkg::CSR_Z_CUTOFF, nsvl_pkg::POS_W'(cutoff));
   endtask

   // Mostly loads and queries on a small table; clear more often once it reaches the cap
   task automatic run_random_phase(input int n_items, input int table_cap);
      nsvl_pkg::req_type item;
      int                pick;
      int                k;
      int                mode;
      repeat (n_items) begin
         item = make_request(nsvl_pkg::ACT_NOP, pick_coord(), pick_coord(), pick_coord(),
                             $urandom, $urandom, $urandom);
         pick = $urandom_range(0, 99);
         k    = (sb.sample_count > 0) ? $urandom_range(0, sb.sample_count - 1) : 0;
         if (pick < 3 || (sb.sample_count >= table_cap && pick < 40)) begin
            item.action = nsvl_pkg::ACT_CLEAR;
         end else if (pick < 48) begin
            item.action = nsvl_pkg::ACT_LOAD;
            // repeat a stored position now and then to force ties
            if (sb.sample_count > 0 && $urandom_range(0, 5) == 0) begin
               item.pos_x = nsvl_pkg::POS_W'(sb.stored_x[k]);
               item.pos_y = nsvl_pkg::POS_W'(sb.stored_y[k]);
               item.pos_z = nsvl_pkg::POS_W'(sb.stored_z[k]);
            end
         end else if (pick < 95) begin
            item.action = nsvl_pkg::ACT_QUERY;
            mode        = $urandom_range(0, 3);
            if (mode == 1 && sb.sample_count > 0) begin
               item.pos_x = nsvl_pkg::POS_W'(sb.stored_x[k] + $urandom_range(0, 8) - 4);
               item.pos_y = nsvl_pkg::POS_W'(sb.stored_y[k] + $urandom_range(0, 8) - 4);
               item.pos_z = nsvl_pkg::POS_W'(sb.stored_z[k] + $urandom_range(0, 8) - 4);
            end else if (mode == 2) begin
               // sit on the height threshold
               item.pos_z = nsvl_pkg::POS_W'(sb.z_base + sb.z_cutoff
                                             + $urandom_range(0, 2) - 1);
            end
         end
         send_request(item);
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_addr  = nsvl_pkg::CSR_Z_BASE;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, field extremes, ties, height boundary, clear, idle action
      send_request(make_request(nsvl_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 0, 0, -1, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_NOP, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom));
      send_request(make_request(nsvl_pkg::ACT_LOAD, 524287, 524287, 524287,
                                'h7fff, 'h8000, 'h5555));
      send_request(make_request(nsvl_pkg::ACT_LOAD, -524288, -524288, -524288,
                                'h8000, 'h7fff, 'haaaa));
      send_request(make_request(nsvl_pkg::ACT_QUERY, -524288, -524288, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 524287, 524287, 524287, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 524287, -524288, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_LOAD, 524287, 524287, 524287,
                                'h1234, 'h5678, 'h9abc));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 524287, 524287, 524287, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_LOAD, 0, 0, 0, 'hffff, 'h0001, 'h8001));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 0, 0, 1, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 5, 5, -1, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0));
      send_request(make_request(nsvl_pkg::ACT_LOAD, 300, -200, 100,
                                'h00ff, 'hff00, 'h0f0f));
      send_request(make_request(nsvl_pkg::ACT_QUERY, 300, -200, 100, 0, 0, 0));

      // Random phases across height settings, extremes after the reset values
      run_random_phase(120, 40);
      set_heights(-524288, 524287);
      run_random_phase(110, 24);
      set_heights(524287, -524288);
      run_random_phase(110, 24);
      set_heights($urandom, $urandom);
      run_random_phase(110, 40);
      set_heights(0, 0);
      idle_on = 1'b0;
      run_random_phase(130, 40);

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("nearest_sample_velocity_lookup_unit verification clean");
      end else begin
         $display("nearest_sample_velocity_lookup_unit verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/nsvl_pkg.sv
hdl/nsvl_ram.sv
hdl/nsvl_front.sv
hdl/nsvl_back.sv
hdl/nearest_sample_velocity_lookup_unit.sv
bench/tb.sv
